FILE: hdl/thermal_code_to_zone_classifier_macros.svh
// ----------------------------------------------------------------------------
// Thermal zone classifier assertion macros
// Shorthand for the concurrent assertions of the checker module.
// ----------------------------------------------------------------------------
`ifndef THERMAL_CODE_TO_ZONE_CLASSIFIER_MACROS_SVH
`define THERMAL_CODE_TO_ZONE_CLASSIFIER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define TCZC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define TCZC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/tczc_pkg.sv
// ----------------------------------------------------------------------------
// Thermal zone classifier package
// Widths, register codes, reset values and the code-to-temperature table.
// ----------------------------------------------------------------------------
package tczc_pkg;

  localparam int CODE_W     = 8;
  localparam int TEMP_W     = 8;
  localparam int ZONE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int LIMIT_REGS = 5;
  localparam int ZONE_COUNT_DEF = 5;
  localparam int ROM_DEPTH  = 93;
  localparam int ROM_IDX_W  = 7;

  localparam logic [ZONE_W-1:0] NO_ZONE = 3'd7;

  localparam logic [CODE_W-1:0] CODE_MAX_VALID  = 8'd128;
  localparam logic [CODE_W-1:0] CODE_LOW_END    = 8'd13;
  localparam logic [CODE_W-1:0] CODE_HIGH_START = 8'd107;
  localparam logic [ROM_IDX_W-1:0] CODE_ROM_BASE = 7'd14;

  localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = -8'sd40;
  localparam logic signed [TEMP_W-1:0] TEMP_CEIL  = 8'sd125;

  typedef logic signed [TEMP_W-1:0] temp_t;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ZONE0_LIMIT = 3'd0,
    REG_ZONE1_LIMIT = 3'd1,
    REG_ZONE2_LIMIT = 3'd2,
    REG_ZONE3_LIMIT = 3'd3,
    REG_ZONE4_LIMIT = 3'd4
  } cfg_reg_t;

  localparam temp_t LIMIT_RESET [LIMIT_REGS] = '{
    8'sd50, 8'sd70, 8'sd85, 8'sd100, 8'sd127
  };

  // Temperature for codes 14 through 106.
  localparam temp_t CODE_ROM [ROM_DEPTH] = '{
    -8'sd38, -8'sd35, -8'sd34, -8'sd32, -8'sd30, -8'sd28, -8'sd26, -8'sd24,
    -8'sd22, -8'sd20, -8'sd18, -8'sd17, -8'sd15, -8'sd13, -8'sd12, -8'sd10,
    -8'sd8,  -8'sd6,  -8'sd5,  -8'sd3,  -8'sd1,  8'sd0,   8'sd2,   8'sd3,
    8'sd5,   8'sd6,   8'sd8,   8'sd10,  8'sd12,  8'sd13,  8'sd15,  8'sd17,
    8'sd19,  8'sd21,  8'sd23,  8'sd25,  8'sd27,  8'sd28,  8'sd30,  8'sd32,
    8'sd33,  8'sd35,  8'sd37,  8'sd38,  8'sd40,  8'sd42,  8'sd43,  8'sd45,
    8'sd47,  8'sd48,  8'sd50,  8'sd52,  8'sd53,  8'sd55,  8'sd57,  8'sd58,
    8'sd60,  8'sd62,  8'sd64,  8'sd66,  8'sd68,  8'sd70,  8'sd71,  8'sd73,
    8'sd75,  8'sd77,  8'sd78,  8'sd80,  8'sd82,  8'sd83,  8'sd85,  8'sd87,
    8'sd88,  8'sd90,  8'sd92,  8'sd93,  8'sd95,  8'sd97,  8'sd98,  8'sd100,
    8'sd102, 8'sd103, 8'sd105, 8'sd107, 8'sd109, 8'sd111, 8'sd113, 8'sd115,
    8'sd117, 8'sd118, 8'sd120, 8'sd122, 8'sd123
  };

  // Converted code handed from the converter to the zone logic.
  typedef struct packed {
    logic  valid;
    temp_t temp;
  } conv_res_t;

  // Zone decision handed from the zone logic to the result register.
  typedef struct packed {
    logic [ZONE_W-1:0] zone;
    logic              changed;
  } zone_res_t;

endpackage

FILE: hdl/tczc_cfg.sv
// ----------------------------------------------------------------------------
// Zone limit registers
// Holds the zone limits and takes writes from the configuration port.
// ----------------------------------------------------------------------------
module tczc_cfg #(
  parameter int ZONE_REGS = tczc_pkg::LIMIT_REGS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [tczc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tczc_pkg::TEMP_W-1:0]             cfg_wdata,
  output logic [ZONE_REGS-1:0][tczc_pkg::TEMP_W-1:0] limits
);
  import tczc_pkg::*;

  logic [ZONE_REGS-1:0][TEMP_W-1:0] limit_r;

  for (genvar i = 0; i < ZONE_REGS; i++) begin : g_limit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        limit_r[i] <= LIMIT_RESET[i];
      end else if (cfg_wr_en && (cfg_index == CFG_IDX_W'(i))) begin
        limit_r[i] <= cfg_wdata;
      end
    end
  end

  assign limits = limit_r;

endmodule

FILE: hdl/tczc_conv.sv
// ----------------------------------------------------------------------------
// Code converter
// Checks the sensor code and maps it to degrees Celsius through the table.
// ----------------------------------------------------------------------------
module tczc_conv (
  input  logic [tczc_pkg::CODE_W-1:0] code,
  output tczc_pkg::conv_res_t         res
);
  import tczc_pkg::*;

  logic [ROM_IDX_W-1:0] rom_idx;

  // Only used for codes 14 to 106, where the top bit is clear.
  assign rom_idx = code[ROM_IDX_W-1:0] - CODE_ROM_BASE;

  always_comb begin
    res.valid = 1'b1;
    if (code > CODE_MAX_VALID) begin
      res.valid = 1'b0;
      res.temp  = '0;
    end else if ((code == CODE_MAX_VALID) || (code <= CODE_LOW_END)) begin
      res.temp = TEMP_FLOOR;
    end else if (code >= CODE_HIGH_START) begin
      res.temp = TEMP_CEIL;
    end else begin
      res.temp = CODE_ROM[rom_idx];
    end
  end

endmodule

FILE: hdl/tczc_zone.sv
// ----------------------------------------------------------------------------
// Zone tracker
// Picks the zone for a temperature and keeps the current zone.
// ----------------------------------------------------------------------------
module tczc_zone #(
  parameter int ZONE_REGS = tczc_pkg::LIMIT_REGS
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       advance,
  input  tczc_pkg::conv_res_t                        conv,
  input  logic [ZONE_REGS-1:0][tczc_pkg::TEMP_W-1:0] limits,
  output tczc_pkg::zone_res_t                        res
);
  import tczc_pkg::*;

  logic [ZONE_W-1:0] current_zone_r;
  logic [ZONE_W-1:0] current_zone_nxt;
  logic [ZONE_W-1:0] pick;

  // The lowest zone whose limit is above the temperature wins; zone 0 if none.
  always_comb begin
    pick = '0;
    for (int i = ZONE_REGS - 1; i >= 0; i--) begin
      if (conv.temp < $signed(limits[i])) begin
        pick = ZONE_W'(i);
      end
    end
  end

  always_comb begin
    if (conv.valid) begin
      current_zone_nxt = pick;
      res.zone         = pick;
      res.changed      = (pick != current_zone_r);
    end else begin
      current_zone_nxt = current_zone_r;
      res.zone         = current_zone_r;
      res.changed      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_zone_r <= NO_ZONE;
    end else if (advance) begin
      current_zone_r <= current_zone_nxt;
    end
  end

endmodule

FILE: hdl/thermal_code_to_zone_classifier.sv
// ----------------------------------------------------------------------------
// Thermal code to zone classifier
// Converts bandgap sensor codes to Celsius and tracks the thermal zone.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   in_*      input      in_valid / in_ready    in_adc_code
//   out_*     output     out_valid / out_ready  out_temp_celsius, out_code_valid,
//                                               out_zone, out_zone_changed
//   cfg_*     input      cfg_wr_en              cfg_index, cfg_wdata
//
// An accepted code passes through the input register and then the result
// register. The code sits in the input register while the table lookup and
// limit compare run, and the result register takes the outcome once it is
// empty or being drained. A new transaction can be accepted every cycle while
// in_ready is high.
// Reset is synchronous and active low; it restores the limit defaults, empties
// both registers and sets the tracked zone to "no zone yet".
// A stalled result holds the result register; the input register then fills,
// and in_ready drops only while both are occupied and out_ready is low.
// ----------------------------------------------------------------------------
module thermal_code_to_zone_classifier #(
  parameter int ZONE_COUNT = tczc_pkg::ZONE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Sensor code transactions.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tczc_pkg::CODE_W-1:0]          in_adc_code,
  // Result transactions.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tczc_pkg::TEMP_W-1:0]   out_temp_celsius,
  output logic                                out_code_valid,
  output logic [tczc_pkg::ZONE_W-1:0]          out_zone,
  output logic                                out_zone_changed,
  // Zone limit writes.
  input  logic                                cfg_wr_en,
  input  logic [tczc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tczc_pkg::TEMP_W-1:0]          cfg_wdata
);
  import tczc_pkg::*;

  // Only the limits that the zone search can reach are stored.
  localparam int ZoneRegs = (ZONE_COUNT < LIMIT_REGS) ? ZONE_COUNT : LIMIT_REGS;

  logic                             in_vld_r;
  logic [CODE_W-1:0]                code_r;
  logic                             out_vld_r;
  temp_t                            temp_r;
  logic                             code_valid_r;
  logic [ZONE_W-1:0]                zone_r;
  logic                             zone_changed_r;

  logic                             out_free;
  logic                             advance;
  logic [ZoneRegs-1:0][TEMP_W-1:0]  limits;
  conv_res_t                        conv;
  zone_res_t                        zres;

  // The result register takes a new value when it is empty or being drained.
  // The input register moves forward whenever the result register can take it,
  // and refills in the same cycle.
  assign out_free = !out_vld_r || out_ready;
  assign advance  = in_vld_r && out_free;
  assign in_ready = !in_vld_r || out_free;

  tczc_cfg #(
    .ZONE_REGS (ZoneRegs)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .limits    (limits)
  );

  tczc_conv u_conv (
    .code (code_r),
    .res  (conv)
  );

  // The tracked zone updates exactly when a transaction enters the result
  // register, so successive transactions see zones in acceptance order.
  tczc_zone #(
    .ZONE_REGS (ZoneRegs)
  ) u_zone (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .conv    (conv),
    .limits  (limits),
    .res     (zres)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_r <= in_adc_code;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      temp_r         <= conv.temp;
      code_valid_r   <= conv.valid;
      zone_r         <= zres.zone;
      zone_changed_r <= zres.changed;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_temp_celsius = temp_r;
  assign out_code_valid   = code_valid_r;
  assign out_zone         = zone_r;
  assign out_zone_changed = zone_changed_r;

endmodule

FILE: hdl/tczc_checker.sv
// ----------------------------------------------------------------------------
// Thermal zone classifier checker
// Port-level assertions on the classifier, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "thermal_code_to_zone_classifier_macros.svh"

module tczc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [tczc_pkg::TEMP_W-1:0] out_temp_celsius,
  input logic                               out_code_valid,
  input logic [tczc_pkg::ZONE_W-1:0]        out_zone,
  input logic                               out_zone_changed
);
  import tczc_pkg::*;

  // A result that waits keeps its contents.
  `TCZC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_temp_celsius) && $stable(out_code_valid) && $stable(out_zone) && $stable(out_zone_changed), "result changed while stalled")

  // A rejected code reports zero degrees and never a zone change.
  `TCZC_ASSERT(a_invalid_quiet, out_valid && !out_code_valid |-> out_temp_celsius == '0 && !out_zone_changed, "rejected code gave a temperature or zone change")

  // An accepted code lands in the sensor range and in a real zone.
  `TCZC_ASSERT(a_valid_range, out_valid && out_code_valid |-> out_temp_celsius >= TEMP_FLOOR && out_temp_celsius <= TEMP_CEIL && out_zone != NO_ZONE, "valid result out of range")

  // Nothing is presented in the cycle after reset.
  `TCZC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind thermal_code_to_zone_classifier tczc_checker u_tczc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_temp_celsius (out_temp_celsius),
  .out_code_valid   (out_code_valid),
  .out_zone         (out_zone),
  .out_zone_changed (out_zone_changed)
);
